// ===== design/sipb_pkg.sv =====
// ----------------------------------------------------------------------------
// sipb_pkg
// Shared types, instruction codes and the register width table for the
// servo instruction packet builder.
// ----------------------------------------------------------------------------
package sipb_pkg;

  localparam logic [7:0] HeaderByte = 8'hFF;

  // Instruction codes
  localparam logic [7:0] OpPing     = 8'd1;
  localparam logic [7:0] OpRead     = 8'd2;
  localparam logic [7:0] OpWrite    = 8'd3;
  localparam logic [7:0] OpRegWrite = 8'd4;
  localparam logic [7:0] OpAction   = 8'd5;
  localparam logic [7:0] OpReset    = 8'd6;

  // Byte positions inside a packet
  localparam logic [3:0] PosHdr0 = 4'd0;
  localparam logic [3:0] PosHdr1 = 4'd1;
  localparam logic [3:0] PosId   = 4'd2;
  localparam logic [3:0] PosLen  = 4'd3;
  localparam logic [3:0] PosOp   = 4'd4;
  localparam logic [3:0] PosBody = 4'd5;

  // Classified packet: everything the serializer needs
  typedef struct packed {
    logic [7:0]       device_id;
    logic [7:0]       len;
    logic [7:0]       op;
    logic [2:0][7:0]  body;
    logic [1:0]       nbody;
    logic [7:0]       csum;
  } pkt_t;

  // Parameter width (1 or 2 bytes) by control table address
  function automatic logic [1:0] reg_width(input logic [7:0] addr);
    logic [1:0] w;
    if (addr < 8'h02)      w = 2'd2;
    else if (addr < 8'h06) w = 2'd1;
    else if (addr < 8'h0B) w = 2'd2;
    else if (addr < 8'h0E) w = 2'd1;
    else if (addr < 8'h10) w = 2'd2;
    else if (addr < 8'h1E) w = 2'd1;
    else if (addr < 8'h2A) w = 2'd2;
    else if (addr < 8'h2F) w = 2'd1;
    else                   w = 2'd2;
    return w;
  endfunction

endpackage

// ===== design/servo_instruction_packet_builder.sv =====
// ----------------------------------------------------------------------------
// servo_instruction_packet_builder
// Turns servo commands into instruction packet byte streams.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers at a rising edge with start high and busy low.
//   Its packet leaves as one byte per cycle on tx_byte_o, marked by
//   strobe_o; last_o flags the checksum byte that closes the packet.
//   A command with no register yields no bytes unless it is ping, action or reset.
//   The command is registered into the queue, and its first header byte is
//   registered out once the serializer is idle. Throughput: one byte per
//   cycle; a packet has 6 to 9 bytes (ping/action/reset and unknown codes 6,
//   read 8, write 8 or 9). Packets follow each other with no gap.
//   A queue of QueueDepth descriptors decouples the classifier from the
//   serializer; busy is high while that queue is full.
//   Reset empties the queue and returns the serializer to the first header
//   byte; strobe_o and last_o are low during reset.
//   The receiver cannot stall: every byte is taken in its cycle.
// ----------------------------------------------------------------------------
module servo_instruction_packet_builder import sipb_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  op_i,
  input  logic [7:0]  device_id_i,
  input  logic [7:0]  reg_addr_i,
  input  logic        reg_given_i,
  input  logic [15:0] param_i,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic        strobe_o
);

  logic accept, push, pop, empty, full;
  pkt_t pkt_in, pkt_head;

  assign busy   = full;
  assign accept = start && !full;

  // Classify incoming commands
  sipb_front u_front (
    .accept_i    (accept),
    .op_i        (op_i),
    .device_id_i (device_id_i),
    .reg_addr_i  (reg_addr_i),
    .reg_given_i (reg_given_i),
    .param_i     (param_i),
    .push_o      (push),
    .pkt_o       (pkt_in)
  );

  // Queue descriptors
  sipb_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (pkt_in),
    .pop_i   (pop),
    .data_o  (pkt_head),
    .empty_o (empty),
    .full_o  (full)
  );

  // Serialize packets
  sipb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pkt_i     (pkt_head),
    .empty_i   (empty),
    .pop_o     (pop),
    .tx_byte_o (tx_byte_o),
    .last_o    (last_o),
    .strobe_o  (strobe_o)
  );

endmodule

// ===== design/sipb_front.sv =====
// ----------------------------------------------------------------------------
// sipb_front
// Classifies one command into a packet descriptor: length byte, body bytes
// and checksum. Only ping, action and reset go out without a register.
// ----------------------------------------------------------------------------
module sipb_front import sipb_pkg::*; (
  input  logic       accept_i,
  input  logic [7:0] op_i,
  input  logic [7:0] device_id_i,
  input  logic [7:0] reg_addr_i,
  input  logic       reg_given_i,
  input  logic [15:0] param_i,
  output logic       push_o,
  output pkt_t       pkt_o
);

  logic       no_reg_needed;
  logic [1:0] width;
  logic [7:0] sum;

  // Decide whether the command yields a packet
  assign no_reg_needed = (op_i == OpPing) || (op_i == OpAction) || (op_i == OpReset);
  assign push_o        = accept_i && (no_reg_needed || reg_given_i);
  assign width         = reg_width(reg_addr_i);

  // Build length and body bytes
  always_comb begin
    pkt_o.device_id = device_id_i;
    pkt_o.op        = op_i;
    pkt_o.body      = '0;
    pkt_o.nbody     = 2'd0;
    pkt_o.len       = 8'd2;
    if (op_i == OpRead) begin
      pkt_o.len     = 8'd4;
      pkt_o.body[0] = reg_addr_i;
      pkt_o.body[1] = {6'd0, width};
      pkt_o.nbody   = 2'd2;
    end else if ((op_i == OpWrite) || (op_i == OpRegWrite)) begin
      pkt_o.len     = {6'd0, width} + 8'd3;
      pkt_o.body[0] = reg_addr_i;
      pkt_o.body[1] = param_i[7:0];
      pkt_o.body[2] = (width == 2'd2) ? param_i[15:8] : 8'd0;
      pkt_o.nbody   = width + 2'd1;
    end
    sum = device_id_i + pkt_o.len + op_i + pkt_o.body[0] + pkt_o.body[1]
        + pkt_o.body[2];
    pkt_o.csum = ~sum;
  end

endmodule

// ===== design/sipb_fifo.sv =====
// ----------------------------------------------------------------------------
// sipb_fifo
// Short descriptor queue between the classifier and the serializer.
// ----------------------------------------------------------------------------
module sipb_fifo import sipb_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pkt_t data_i,
  input  logic pop_i,
  output pkt_t data_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  pkt_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Store descriptors
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/sipb_back.sv =====
// ----------------------------------------------------------------------------
// sipb_back
// Serializes the head descriptor, one packet byte per cycle, and pops it
// after the checksum byte.
// ----------------------------------------------------------------------------
module sipb_back import sipb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pkt_t       pkt_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic [7:0] tx_byte_o,
  output logic       last_o,
  output logic       strobe_o
);

  logic [3:0] pos_q, pos_d;
  logic [3:0] csum_pos;
  logic [1:0] body_idx;
  logic [7:0] byte_d;
  logic       last_d;
  logic [7:0] tx_byte_q;
  logic       last_q, strobe_q;

  assign csum_pos = PosBody + {2'd0, pkt_i.nbody};
  assign body_idx = 2'(pos_q - PosBody);
  assign last_d   = (pos_q == csum_pos);
  assign pop_o    = !empty_i && last_d;

  // Select the byte at the current position
  always_comb begin
    case (pos_q)
      PosHdr0: byte_d = HeaderByte;
      PosHdr1: byte_d = HeaderByte;
      PosId:   byte_d = pkt_i.device_id;
      PosLen:  byte_d = pkt_i.len;
      PosOp:   byte_d = pkt_i.op;
      default: byte_d = last_d ? pkt_i.csum : pkt_i.body[body_idx];
    endcase
  end

  // Step through the packet; wrap after the checksum
  always_comb begin
    pos_d = pos_q;
    if (!empty_i) begin
      pos_d = last_d ? PosHdr0 : pos_q + 4'd1;
    end
  end

  // Hold the byte counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= PosHdr0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      strobe_q <= !empty_i;
      last_q   <= !empty_i && last_d;
    end
  end

  // Register the outgoing byte
  always_ff @(posedge clk_i) begin
    tx_byte_q <= byte_d;
  end

  assign tx_byte_o = tx_byte_q;
  assign last_o    = last_q;
  assign strobe_o  = strobe_q;

endmodule

// ===== design/sipb_checker.sv =====
// ----------------------------------------------------------------------------
// sipb_checker
// Port-level checks on the packet byte stream of the packet builder.
// ----------------------------------------------------------------------------
module sipb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic [7:0] tx_byte_o,
  input logic       last_o,
  input logic       strobe_o
);

  // Checksum flag only on a strobed byte
  a_last_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> strobe_o)
    else $error("last_o without strobe_o");

  // A packet is never a single byte long
  a_no_double_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |=> !last_o)
    else $error("checksum bytes back to back");

  // A byte right after a checksum opens a new packet with a header
  a_hdr_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) ##1 strobe_o |-> (tx_byte_o == 8'hFF))
    else $error("packet does not start with header byte");

  // A burst starts with a header byte, never a checksum
  a_hdr_on_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(strobe_o) |-> ((tx_byte_o == 8'hFF) && !last_o))
    else $error("byte burst does not start with header");

endmodule

bind servo_instruction_packet_builder sipb_checker u_sipb_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .tx_byte_o (tx_byte_o),
  .last_o    (last_o),
  .strobe_o  (strobe_o)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the servo instruction packet builder. Commands are
// queued up front (a directed set, then random ones), pushed into the block
// by a clocked driver with random gaps, and every strobed packet byte is
// compared against bytes predicted at the moment the command transfers.
// ----------------------------------------------------------------------------
module tb_top import sipb_pkg::*;;

  typedef struct packed {
    logic [7:0]  op;
    logic [7:0]  id;
    logic [7:0]  addr;
    logic        given;
    logic [15:0] param;
  } servo_cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_beat_t;

  localparam int RandomCmds   = 400;
  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 20;
  localparam int MaxReported  = 10;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  logic [7:0]  op_i        = '0;
  logic [7:0]  device_id_i = '0;
  logic [7:0]  reg_addr_i  = '0;
  logic        reg_given_i = 1'b0;
  logic [15:0] param_i     = '0;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic        strobe_o;

  servo_cmd_t pending_cmds[$];
  tx_beat_t   expected_bytes[$];
  servo_cmd_t cur_cmd;
  int         total_cmds  = 0;
  int         n_accepted  = 0;
  int         n_mismatch  = 0;
  int         cycle_count = 0;
  bit         draining    = 1'b0;

  servo_instruction_packet_builder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .device_id_i (device_id_i),
    .reg_addr_i  (reg_addr_i),
    .reg_given_i (reg_given_i),
    .param_i     (param_i),
    .tx_byte_o   (tx_byte_o),
    .last_o      (last_o),
    .strobe_o    (strobe_o)
  );

  // Clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Parameter byte count by control table address
  function automatic int param_width(input logic [7:0] addr);
    if (addr >= 8'h2F) return 2;
    if (addr >= 8'h2A) return 1;
    if (addr >= 8'h1E) return 2;
    if (addr >= 8'h10) return 1;
    if (addr >= 8'h0E) return 2;
    if (addr >= 8'h0B) return 1;
    if (addr >= 8'h06) return 2;
    if (addr >= 8'h02) return 1;
    return 2;
  endfunction

  task automatic expect_beat(input logic [7:0] data, input logic last);
    tx_beat_t b;
    b.data = data;
    b.last = last;
    expected_bytes.insert(expected_bytes.size(), b);
  endtask

  // Build the packet a command should produce and queue its bytes
  task automatic queue_packet_bytes(input servo_cmd_t c);
    logic [7:0] body [3];
    int         nbody;
    int         w;
    logic [7:0] len;
    logic [7:0] sum;
    nbody = 0;
    if (!(c.op == OpPing || c.op == OpAction || c.op == OpReset) && !c.given) return;
    w = param_width(c.addr);
    if (c.op == OpRead) begin
      len = 8'd4;
      body[0] = c.addr;
      body[1] = 8'(w);
      nbody = 2;
    end else if (c.op == OpWrite || c.op == OpRegWrite) begin
      len = 8'(w + 3);
      body[0] = c.addr;
      body[1] = c.param[7:0];
      body[2] = c.param[15:8];
      nbody = w + 1;
    end else begin
      len = 8'd2;
    end
    expect_beat(HeaderByte, 1'b0);
    expect_beat(HeaderByte, 1'b0);
    expect_beat(c.id, 1'b0);
    expect_beat(len, 1'b0);
    expect_beat(c.op, 1'b0);
    sum = c.id + len + c.op;
    for (int i = 0; i < nbody; i++) begin
      expect_beat(body[i], 1'b0);
      sum = sum + body[i];
    end
    expect_beat(~sum, 1'b1);
  endtask

  task automatic add_cmd(input logic [7:0] op, input logic [7:0] id, input logic [7:0] addr,
                         input logic given, input logic [15:0] param);
    servo_cmd_t c;
    c.op    = op;
    c.id    = id;
    c.addr  = addr;
    c.given = given;
    c.param = param;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic report_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= MaxReported) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Drive commands; advance on each transfer, idle at the rate of the phase
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic present;
    int   idle_pct;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      present = start;
      if (start && !busy) begin
        queue_packet_bytes(cur_cmd);
        n_accepted++;
        present = 1'b0;
        // hold off until the block drains, twice per run
        if (n_accepted == total_cmds / 3 || n_accepted == 2 * total_cmds / 3 + 10) begin
          draining = 1'b1;
        end
      end
      if (n_accepted < total_cmds / 3) idle_pct = 37;
      else if (n_accepted < 2 * total_cmds / 3) idle_pct = 70;
      else idle_pct = 0;
      if (draining && expected_bytes.size() == 0) draining = 1'b0;
      if (!present && !draining && pending_cmds.size() > 0 &&
          $urandom_range(99) >= idle_pct) begin
        cur_cmd = pending_cmds.pop_front();
        op_i        <= cur_cmd.op;
        device_id_i <= cur_cmd.id;
        reg_addr_i  <= cur_cmd.addr;
        reg_given_i <= cur_cmd.given;
        param_i     <= cur_cmd.param;
        present = 1'b1;
      end
      start <= present;
    end
  end

  // Check each strobed byte against the oldest predicted one
  always @(posedge clk_i) begin : monitor
    tx_beat_t exp_beat;
    if (rst_ni && strobe_o) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", tx_byte_o, last_o));
      end else begin
        exp_beat = expected_bytes.pop_front();
        if (tx_byte_o !== exp_beat.data) begin
          report_mismatch($sformatf("tx_byte expected %02h got %02h", exp_beat.data, tx_byte_o));
        end
        if (last_o !== exp_beat.last) begin
          report_mismatch($sformatf("last expected %0b got %0b (byte %02h)",
                                    exp_beat.last, last_o, tx_byte_o));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** servo_instruction_packet_builder: FAILED **");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    servo_cmd_t c;
    // register-free instructions, with and without a register given
    add_cmd(OpPing,   8'h01, 8'h00, 1'b0, 16'h0000);
    add_cmd(OpPing,   8'hFF, 8'h1E, 1'b1, 16'hFFFF);
    add_cmd(OpAction, 8'h00, 8'h00, 1'b0, 16'h0000);
    add_cmd(OpReset,  8'hFE, 8'hFF, 1'b1, 16'h5555);
    // reads across the width table
    add_cmd(OpRead, 8'h01, 8'h00, 1'b1, 16'h0000);
    add_cmd(OpRead, 8'hFF, 8'h05, 1'b1, 16'hFFFF);
    add_cmd(OpRead, 8'h7F, 8'hFF, 1'b1, 16'h0000);
    // writes at every table boundary
    add_cmd(OpWrite,    8'h02, 8'h01, 1'b1, 16'hFFFF);
    add_cmd(OpWrite,    8'h03, 8'h02, 1'b1, 16'h1234);
    add_cmd(OpWrite,    8'h04, 8'h06, 1'b1, 16'hABCD);
    add_cmd(OpWrite,    8'h05, 8'h0B, 1'b1, 16'h0000);
    add_cmd(OpWrite,    8'h06, 8'h0E, 1'b1, 16'hFFFF);
    add_cmd(OpRegWrite, 8'h07, 8'h10, 1'b1, 16'h00FF);
    add_cmd(OpRegWrite, 8'h08, 8'h1D, 1'b1, 16'hFF00);
    add_cmd(OpRegWrite, 8'h09, 8'h1E, 1'b1, 16'h8001);
    add_cmd(OpWrite,    8'hFE, 8'h29, 1'b1, 16'h7FFE);
    add_cmd(OpWrite,    8'h00, 8'h2A, 1'b1, 16'h5A5A);
    add_cmd(OpRegWrite, 8'hFF, 8'h2E, 1'b1, 16'hA5A5);
    add_cmd(OpWrite,    8'h80, 8'h2F, 1'b1, 16'hFFFF);
    // missing register drops the command
    add_cmd(OpRead,     8'h11, 8'h20, 1'b0, 16'h1111);
    add_cmd(OpWrite,    8'h12, 8'h20, 1'b0, 16'h2222);
    add_cmd(OpRegWrite, 8'h13, 8'h20, 1'b0, 16'h3333);
    add_cmd(8'd0,       8'h14, 8'h20, 1'b0, 16'h4444);
    // unknown codes give a bare packet
    add_cmd(8'd0,   8'h15, 8'h03, 1'b1, 16'hFFFF);
    add_cmd(8'd7,   8'h16, 8'hFF, 1'b1, 16'h0000);
    add_cmd(8'd255, 8'h17, 8'h00, 1'b1, 16'h8000);

    // random commands, mostly valid instructions with a register given
    for (int k = 0; k < RandomCmds; k++) begin
      c.op    = ($urandom_range(99) < 85) ? 8'($urandom_range(OpPing, OpReset))
                                          : 8'($urandom_range(255));
      c.id    = 8'($urandom_range(255));
      c.addr  = $urandom_range(1) ? 8'($urandom_range(8'h30)) : 8'($urandom_range(255));
      c.given = ($urandom_range(9) != 0);
      c.param = 16'($urandom_range(16'hFFFF));
      pending_cmds.insert(pending_cmds.size(), c);
    end
    total_cmds = pending_cmds.size();

    while (n_accepted < total_cmds) @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("** servo_instruction_packet_builder: PASSED **");
    end else begin
      $display("** servo_instruction_packet_builder: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/sipb_pkg.sv
design/sipb_front.sv
design/sipb_fifo.sv
design/sipb_back.sv
design/servo_instruction_packet_builder.sv
design/sipb_checker.sv
verif/tb_top.sv
